[rtl/sliding_window_anagram_search_top_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the sliding-window anagram search block
// Concurrent checks, compiled out when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_ANAGRAM_SEARCH_TOP_MACROS_SVH
`define SLIDING_WINDOW_ANAGRAM_SEARCH_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// Check outside of reset.
`define SWAS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Check on every edge, reset included.
`define SWAS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SWAS_ASSERT(lbl, clk, rstn, prop, msg)
`define SWAS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[rtl/swas_pkg.sv]
// ----------------------------------------------------------------------------
// swas_pkg
// Types, constants and helpers of the sliding-window anagram search.
// ----------------------------------------------------------------------------
package swas_pkg;

  localparam int MaxPattern = 64;
  localparam int Alphabet   = 26;
  // One extra bin collects text letters outside the alphabet.
  localparam int NumBins    = Alphabet + 1;

  localparam int LetterW = 5;
  localparam int PosW    = 32;
  localparam int CntW    = $clog2(MaxPattern + 1);
  localparam int RingAw  = (MaxPattern > 1) ? $clog2(MaxPattern) : 1;
  localparam int BinW    = $clog2(NumBins);
  // Per-bin difference lies in -MaxPattern..MaxPattern, kept modulo 2**DiffW.
  localparam int DiffW   = $clog2(MaxPattern + 1) + 1;
  localparam int DifW    = $clog2(NumBins + 1);

  typedef enum logic [1:0] {
    OpClear   = 2'd0,
    OpPattern = 2'd1,
    OpText    = 2'd2
  } op_e;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [LetterW-1:0] letter;
  } in_t;

  typedef struct packed {
    logic            match;
    logic [PosW-1:0] start_index;
  } out_t;

  // Map a letter code to its histogram bin.
  function automatic logic [BinW-1:0] bin_of(logic [LetterW-1:0] code);
    logic [BinW-1:0] bin;
    if (code < LetterW'(Alphabet)) begin
      bin = BinW'(code);
    end else begin
      bin = BinW'(Alphabet);
    end
    return bin;
  endfunction

endpackage

[rtl/sliding_window_anagram_search_top.sv]
// ----------------------------------------------------------------------------
// sliding_window_anagram_search_top
// Streaming anagram search: pattern histogram against a sliding text window.
// ----------------------------------------------------------------------------
//
//   channel | direction | payload | handshake
//   --------+-----------+---------+------------------------------
//   in      | input     | in_t    | in_valid_i / in_ready_o
//   out     | output    | out_t   | out_valid_o / out_ready_i
//
// One input transaction per cycle is sustained while the output queue is not
// fully reserved. A text letter's result passes the ring read, then the
// histogram read-modify-write, then the output queue before it shows on out.
// Clear and pattern letters produce no output transaction.
// Reset clears the histograms at once through per-bin valid bits; no sweep.
// in_ready_o drops only when the four-entry output queue is fully reserved
// by results not yet taken, so out_ready_i low for a while stalls the input.
// ----------------------------------------------------------------------------
`include "sliding_window_anagram_search_top_macros.svh"

module sliding_window_anagram_search_top import swas_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  in_t  in_data_i,
  input  logic in_valid_i,
  output logic in_ready_o,
  output out_t out_data_o,
  output logic out_valid_o,
  input  logic out_ready_i
);

  localparam int FifoDepth = 4;
  localparam int FifoAw    = 2;
  localparam int FifoCntW  = 3;
  localparam int RptW      = RingAw + 1;

  typedef struct packed {
    logic            valid;
    op_e             kind;
    logic            upd;    // histogram update (accepted pattern or live text)
    logic            leave;  // a letter drops out of the window
    logic            full;   // window holds a full pattern length
    logic [BinW-1:0] ebin;   // bin of the letter entering (or pattern letter)
    logic [PosW-1:0] pos;
    logic [CntW-1:0] len;
  } s1_t;

  typedef struct packed {
    logic            valid;
    op_e             kind;
    logic            upd;
    logic            leave;
    logic            full;
    logic [BinW-1:0] ebin;
    logic [BinW-1:0] lbin;
    logic [PosW-1:0] start;
  } s2_t;

  // --------------------------------------------------------------------------
  // Accept stage: search position, pattern length and ring pointer
  // --------------------------------------------------------------------------
  logic              in_fire;
  op_e               op;
  logic [LetterW-1:0] code;
  logic [PosW-1:0]   pos_q, pos_d;
  logic [CntW-1:0]   len_q, len_d;
  logic [RingAw-1:0] wptr_q, wptr_d;
  logic              pos_sat, text_upd, pat_ok, is_text;
  logic [RptW-1:0]   rd_sum;
  logic [RingAw-1:0] rd_addr;

  assign in_fire = in_valid_i && in_ready_o;
  assign op      = op_e'(in_data_i.opcode);
  assign code    = in_data_i.letter;
  assign is_text = (op == OpText);
  assign pos_sat = &pos_q;
  // Text letters touch the histograms only with a pattern and a live position.
  assign text_upd = is_text && !pos_sat && (len_q != '0);
  // Pattern letters count only before text starts, up to the length limit.
  assign pat_ok = (op == OpPattern) && (pos_q == '0) && (len_q < CntW'(MaxPattern))
                  && (code < LetterW'(Alphabet));

  // Ring slot of the letter that entered len_q text letters ago.
  always_comb begin
    if (RptW'(wptr_q) >= RptW'(len_q)) begin
      rd_sum = RptW'(wptr_q) - RptW'(len_q);
    end else begin
      rd_sum = RptW'(wptr_q) + RptW'(MaxPattern) - RptW'(len_q);
    end
    rd_addr = rd_sum[RingAw-1:0];
  end

  always_comb begin
    pos_d  = pos_q;
    len_d  = len_q;
    wptr_d = wptr_q;
    case (op)
      OpClear: begin
        pos_d  = '0;
        len_d  = '0;
        wptr_d = '0;
      end
      OpPattern: begin
        if (pat_ok) begin
          len_d = len_q + CntW'(1);
        end
      end
      OpText: begin
        if (!pos_sat) begin
          pos_d = pos_q + PosW'(1);
        end
        if (text_upd) begin
          if (wptr_q == RingAw'(MaxPattern - 1)) begin
            wptr_d = '0;
          end else begin
            wptr_d = wptr_q + RingAw'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      len_q  <= '0;
      wptr_q <= '0;
    end else if (in_fire) begin
      pos_q  <= pos_d;
      len_q  <= len_d;
      wptr_q <= wptr_d;
    end
  end

  // Ring of recent text letters; read returns the old entry on a collision,
  // which is the one leaving when the pattern fills the whole ring.
  logic [LetterW-1:0] ring_mem [MaxPattern];
  logic [LetterW-1:0] ring_rd_q;

  always_ff @(posedge clk_i) begin
    if (in_fire && text_upd) begin
      ring_mem[wptr_q] <= code;
    end
    ring_rd_q <= ring_mem[rd_addr];
  end

  // --------------------------------------------------------------------------
  // Stage 1: leaving letter known, issue histogram reads
  // --------------------------------------------------------------------------
  s1_t s1_q;
  s1_t s1_d;

  always_comb begin
    s1_d.valid = in_fire;
    s1_d.kind  = op;
    s1_d.upd   = text_upd || pat_ok;
    s1_d.leave = text_upd && (pos_q >= PosW'(len_q));
    s1_d.full  = pos_q >= (PosW'(len_q) - PosW'(1));
    s1_d.ebin  = bin_of(code);
    s1_d.pos   = pos_q;
    s1_d.len   = len_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
    end else begin
      s1_q <= s1_d;
    end
  end

  logic [BinW-1:0] s1_lbin;
  assign s1_lbin = bin_of(ring_rd_q);

  // Two histogram memories: ent_mem holds letters entered minus pattern
  // letters, lev_mem holds letters that left. Their difference per bin is
  // window minus pattern, modulo 2**DiffW. Valid bits make a clear instant.
  logic [DiffW-1:0]   ent_mem [NumBins];
  logic [DiffW-1:0]   lev_mem [NumBins];
  logic [NumBins-1:0] ent_vld_q;
  logic [NumBins-1:0] lev_vld_q;
  logic [DiffW-1:0]   ent_e_q, ent_l_q, lev_e_q, lev_l_q;
  logic               ent_ve_q, ent_vl_q, lev_ve_q, lev_vl_q;

  // Stage 2 write controls, declared here for the memory blocks.
  logic             a_we, b_we, clr_s2;
  logic [DiffW-1:0] a_wdata, b_wdata;
  s2_t              s2_q;

  always_ff @(posedge clk_i) begin
    ent_e_q <= ent_mem[s1_q.ebin];
    ent_l_q <= ent_mem[s1_lbin];
    lev_e_q <= lev_mem[s1_q.ebin];
    lev_l_q <= lev_mem[s1_lbin];
    if (a_we) begin
      ent_mem[s2_q.ebin] <= a_wdata;
    end
    if (b_we) begin
      lev_mem[s2_q.lbin] <= b_wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_vld_q <= '0;
      lev_vld_q <= '0;
      ent_ve_q  <= 1'b0;
      ent_vl_q  <= 1'b0;
      lev_ve_q  <= 1'b0;
      lev_vl_q  <= 1'b0;
    end else begin
      ent_ve_q <= ent_vld_q[s1_q.ebin];
      ent_vl_q <= ent_vld_q[s1_lbin];
      lev_ve_q <= lev_vld_q[s1_q.ebin];
      lev_vl_q <= lev_vld_q[s1_lbin];
      if (clr_s2) begin
        ent_vld_q <= '0;
        lev_vld_q <= '0;
      end else begin
        if (a_we) begin
          ent_vld_q[s2_q.ebin] <= 1'b1;
        end
        if (b_we) begin
          lev_vld_q[s2_q.lbin] <= 1'b1;
        end
      end
    end
  end

  s2_t s2_d;

  always_comb begin
    s2_d.valid = s1_q.valid;
    s2_d.kind  = s1_q.kind;
    s2_d.upd   = s1_q.upd;
    s2_d.leave = s1_q.leave;
    s2_d.full  = s1_q.full;
    s2_d.ebin  = s1_q.ebin;
    s2_d.lbin  = s1_lbin;
    s2_d.start = s1_q.pos + PosW'(1) - PosW'(s1_q.len);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_q <= '0;
    end else begin
      s2_q <= s2_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: read-modify-write of the histograms and the differing-bin count
  // --------------------------------------------------------------------------
  // The previous stage-2 transaction wrote at the same edge as our read;
  // forward its write (or its clear) over the stale memory data.
  logic             fwd_clr_q, fwd_a_we_q, fwd_b_we_q;
  logic [BinW-1:0]  fwd_a_addr_q, fwd_b_addr_q;
  logic [DiffW-1:0] fwd_a_data_q, fwd_b_data_q;

  logic [DiffW-1:0] a_e, a_l, b_e, b_l, de, dl;
  logic [DifW-1:0]  dif_q, dif_d;
  logic             inc_e, dec_e, inc_l, dec_l;
  logic             push, res_match;

  always_comb begin
    if (fwd_clr_q) begin
      a_e = '0;
      a_l = '0;
      b_e = '0;
      b_l = '0;
    end else begin
      a_e = (fwd_a_we_q && fwd_a_addr_q == s2_q.ebin) ? fwd_a_data_q :
            (ent_ve_q ? ent_e_q : '0);
      a_l = (fwd_a_we_q && fwd_a_addr_q == s2_q.lbin) ? fwd_a_data_q :
            (ent_vl_q ? ent_l_q : '0);
      b_e = (fwd_b_we_q && fwd_b_addr_q == s2_q.ebin) ? fwd_b_data_q :
            (lev_ve_q ? lev_e_q : '0);
      b_l = (fwd_b_we_q && fwd_b_addr_q == s2_q.lbin) ? fwd_b_data_q :
            (lev_vl_q ? lev_l_q : '0);
    end
    de = a_e - b_e;
    dl = a_l - b_l;
  end

  always_comb begin
    a_we    = 1'b0;
    b_we    = 1'b0;
    clr_s2  = 1'b0;
    a_wdata = a_e;
    b_wdata = b_l;
    inc_e   = 1'b0;
    dec_e   = 1'b0;
    inc_l   = 1'b0;
    dec_l   = 1'b0;
    push    = 1'b0;
    if (s2_q.valid) begin
      case (s2_q.kind)
        OpClear: begin
          clr_s2 = 1'b1;
        end
        OpPattern: begin
          if (s2_q.upd) begin
            a_we    = 1'b1;
            a_wdata = a_e - DiffW'(1);
            inc_e   = (de == '0);
            dec_e   = (de == DiffW'(1));
          end
        end
        OpText: begin
          push = 1'b1;
          if (s2_q.upd) begin
            a_we    = 1'b1;
            a_wdata = a_e + DiffW'(1);
            if (s2_q.leave) begin
              b_we    = 1'b1;
              b_wdata = b_l + DiffW'(1);
            end
            // Same bin in and out: the window count is unchanged.
            if (!(s2_q.leave && s2_q.lbin == s2_q.ebin)) begin
              inc_e = (de == '0);
              dec_e = (de == '1);
              if (s2_q.leave) begin
                inc_l = (dl == '0);
                dec_l = (dl == DiffW'(1));
              end
            end
          end
        end
        default: ;
      endcase
    end
    if (clr_s2) begin
      dif_d = '0;
    end else begin
      dif_d = dif_q + DifW'(inc_e) + DifW'(inc_l) - DifW'(dec_e) - DifW'(dec_l);
    end
    res_match = s2_q.upd && s2_q.full && (dif_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dif_q      <= '0;
      fwd_clr_q  <= 1'b0;
      fwd_a_we_q <= 1'b0;
      fwd_b_we_q <= 1'b0;
    end else begin
      dif_q      <= dif_d;
      fwd_clr_q  <= clr_s2;
      fwd_a_we_q <= a_we;
      fwd_b_we_q <= b_we;
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_a_addr_q <= s2_q.ebin;
    fwd_a_data_q <= a_wdata;
    fwd_b_addr_q <= s2_q.lbin;
    fwd_b_data_q <= b_wdata;
  end

  // --------------------------------------------------------------------------
  // Output queue; every accepted text letter reserves one slot up front
  // --------------------------------------------------------------------------
  out_t                fifo_mem [FifoDepth];
  logic [FifoAw-1:0]   fifo_wp_q, fifo_rp_q;
  logic [FifoCntW-1:0] fifo_cnt_q, rsv_q;
  logic                pop;
  out_t                push_data;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (fifo_cnt_q != '0);
  assign out_data_o  = fifo_mem[fifo_rp_q];
  assign in_ready_o  = (rsv_q < FifoCntW'(FifoDepth));

  always_comb begin
    push_data.match       = res_match;
    push_data.start_index = res_match ? s2_q.start : '0;
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_mem[fifo_wp_q] <= push_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fifo_wp_q  <= '0;
      fifo_rp_q  <= '0;
      fifo_cnt_q <= '0;
      rsv_q      <= '0;
    end else begin
      if (push) begin
        fifo_wp_q <= fifo_wp_q + FifoAw'(1);
      end
      if (pop) begin
        fifo_rp_q <= fifo_rp_q + FifoAw'(1);
      end
      fifo_cnt_q <= fifo_cnt_q + FifoCntW'(push) - FifoCntW'(pop);
      rsv_q      <= rsv_q + FifoCntW'(in_fire && is_text) - FifoCntW'(pop);
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `SWAS_ASSERT_ALWAYS(a_rsv_bound, clk_i, !rst_ni || (rsv_q <= FifoCntW'(FifoDepth)),
    "output reservations exceed queue depth")
  `SWAS_ASSERT(a_rsv_track, clk_i, rst_ni,
    rsv_q == fifo_cnt_q + FifoCntW'(s1_q.valid && s1_q.kind == OpText)
             + FifoCntW'(s2_q.valid && s2_q.kind == OpText),
    "reservations disagree with results in flight")
  `SWAS_ASSERT(a_dif_bound, clk_i, rst_ni, dif_q <= DifW'(NumBins),
    "differing-bin count out of range")
  `SWAS_ASSERT(a_clear_zero, clk_i, rst_ni,
    (in_fire && op == OpClear) |=> (pos_q == '0 && len_q == '0 && wptr_q == '0),
    "clear did not restart the search")

endmodule

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sliding-window anagram search. A directed table
// hits empty patterns, out-of-alphabet letters, pattern overflow and late
// pattern letters. Random searches then stream permuted pattern copies through
// text so that matches are frequent. Every text letter is scored, under random
// stalls on both channels, against a typed result or the histogram predictor.
// ----------------------------------------------------------------------------
module tb_top;
  import swas_pkg::*;

  // Reserved opcode: the block drops it silently.
  localparam logic [1:0] OpUnused = 2'd3;

  localparam int IdlePct     = 19;
  localparam int HoldCycles  = 200;
  localparam int DrainCycles = 16;
  localparam int CycleLimit  = 200000;
  // Directed rows issue about 210 transactions; random searches fill the rest.
  localparam int ItemTarget  = 1900;
  localparam int NumRows     = 22;

  // One row of the directed table. Rows with a typed result carry it here;
  // the rest are scored by the predictor.
  typedef struct packed {
    in_t             item;
    logic [6:0]      reps;
    logic            typed;
    logic            t_match;
    logic [PosW-1:0] t_start;
  } row_t;

  logic clk_i      = 1'b0;
  logic rst_ni     = 1'b0;
  in_t  in_data    = '0;
  logic in_valid   = 1'b0;
  logic in_ready_o;
  out_t out_data_o;
  logic out_valid_o;
  logic out_ready  = 1'b0;

  // Shared knobs between stimulus and result sink.
  bit idle_on       = 1'b1;
  bit long_hold_req = 1'b0;

  int unsigned cycle_cnt    = 0;
  int unsigned items_sent   = 0;
  int unsigned mismatch_cnt = 0;

  // Predicted results, oldest first.
  out_t pending_windows[$];

  // Predictor state: histograms with the extra bin, ring of recent text letters.
  logic [6:0]         pat_hist [NumBins];
  logic [6:0]         win_hist [NumBins];
  logic [LetterW-1:0] recent_ring [MaxPattern];
  logic [6:0]         pat_len    = '0;
  logic [PosW-1:0]    text_pos   = '0;
  logic [4:0]         diff_bins  = '0;

  row_t directed [NumRows] = '{
    // Fresh from reset the pattern is empty: text never matches.
    '{'{OpText,    5'd0 }, 7'd1,  1'b1, 1'b0, 32'd0 },
    // Restart so that the pattern letters below are taken.
    '{'{OpClear,   5'd0 }, 7'd1,  1'b0, 1'b0, 32'd0 },
    // Reserved opcode and an out-of-alphabet pattern letter are dropped.
    '{'{OpUnused,  5'd31}, 7'd1,  1'b0, 1'b0, 32'd0 },
    '{'{OpPattern, 5'd31}, 7'd1,  1'b0, 1'b0, 32'd0 },
    // Pattern "az".
    '{'{OpPattern, 5'd0 }, 7'd1,  1'b0, 1'b0, 32'd0 },
    '{'{OpPattern, 5'd25}, 7'd1,  1'b0, 1'b0, 32'd0 },
    '{'{OpText,    5'd25}, 7'd1,  1'b1, 1'b0, 32'd0 },
    '{'{OpText,    5'd0 }, 7'd1,  1'b1, 1'b1, 32'd0 },
    // Pattern letter once text has begun: ignored.
    '{'{OpPattern, 5'd1 }, 7'd1,  1'b0, 1'b0, 32'd0 },
    // Out-of-alphabet text letter spoils the windows that hold it.
    '{'{OpText,    5'd26}, 7'd1,  1'b1, 1'b0, 32'd0 },
    '{'{OpText,    5'd25}, 7'd1,  1'b1, 1'b0, 32'd0 },
    '{'{OpText,    5'd0 }, 7'd1,  1'b1, 1'b1, 32'd3 },
    // Clear, then text with an empty pattern.
    '{'{OpClear,   5'd0 }, 7'd1,  1'b0, 1'b0, 32'd0 },
    '{'{OpText,    5'd31}, 7'd1,  1'b1, 1'b0, 32'd0 },
    '{'{OpClear,   5'd31}, 7'd1,  1'b0, 1'b0, 32'd0 },
    // Longest pattern plus one extra letter that must be dropped.
    '{'{OpPattern, 5'd7 }, 7'd65, 1'b0, 1'b0, 32'd0 },
    '{'{OpText,    5'd7 }, 7'd63, 1'b0, 1'b0, 32'd0 },
    '{'{OpText,    5'd7 }, 7'd1,  1'b1, 1'b1, 32'd0 },
    '{'{OpText,    5'd7 }, 7'd1,  1'b1, 1'b1, 32'd1 },
    // Bad letter rides the full window through ring wrap, then leaves.
    '{'{OpText,    5'd30}, 7'd1,  1'b1, 1'b0, 32'd0 },
    '{'{OpText,    5'd7 }, 7'd63, 1'b0, 1'b0, 32'd0 },
    '{'{OpText,    5'd7 }, 7'd1,  1'b1, 1'b1, 32'd66}
  };

  sliding_window_anagram_search_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .out_data_o  (out_data_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready)
  );

  always #2 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic int unsigned letter_bin(logic [LetterW-1:0] code);
    return (code < Alphabet) ? int'(code) : Alphabet;
  endfunction

  function automatic void clear_search();
    for (int b = 0; b < NumBins; b++) begin
      pat_hist[b] = '0;
      win_hist[b] = '0;
    end
    pat_len   = '0;
    text_pos  = '0;
    diff_bins = '0;
  endfunction

  // Move one bin up or down and keep the count of differing bins current.
  function automatic void bump_bin(bit in_window, int unsigned bin, bit up);
    bit was_diff;
    bit now_diff;
    was_diff = (pat_hist[bin] != win_hist[bin]);
    if (!in_window) begin
      pat_hist[bin] = pat_hist[bin] + 7'd1;
    end else if (up) begin
      win_hist[bin] = win_hist[bin] + 7'd1;
    end else if (win_hist[bin] != 0) begin
      win_hist[bin] = win_hist[bin] - 7'd1;
    end
    now_diff = (pat_hist[bin] != win_hist[bin]);
    if (was_diff && !now_diff && diff_bins != 0) begin
      diff_bins = diff_bins - 5'd1;
    end else if (!was_diff && now_diff) begin
      diff_bins = diff_bins + 5'd1;
    end
  endfunction

  // Apply one accepted transaction; report whether it yields a result.
  function automatic void search_step(input in_t item, output bit produces,
                                      output out_t res);
    logic [PosW-1:0]    pos;
    logic [PosW-1:0]    m;
    logic [LetterW-1:0] leaving;
    produces = 1'b0;
    res      = '0;
    case (item.opcode)
      OpClear: begin
        clear_search();
      end
      OpPattern: begin
        if (text_pos == 0 && pat_len < MaxPattern && item.letter < Alphabet) begin
          bump_bin(1'b0, letter_bin(item.letter), 1'b1);
          pat_len = pat_len + 7'd1;
        end
      end
      OpText: begin
        produces = 1'b1;
        pos      = text_pos;
        m        = PosW'(pat_len);
        if (pos != '1) begin
          text_pos = pos + 1;
          if (m != 0) begin
            if (pos >= m) begin
              leaving = recent_ring[(pos - m) % MaxPattern];
              bump_bin(1'b1, letter_bin(leaving), 1'b0);
            end
            recent_ring[pos % MaxPattern] = item.letter;
            bump_bin(1'b1, letter_bin(item.letter), 1'b1);
            if (pos + 1 >= m && diff_bins == 0) begin
              res.match       = 1'b1;
              res.start_index = pos + 1 - m;
            end
          end
        end
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Offer one transaction, hold it until accepted, then log the expectation.
  // A typed result replaces the predicted one for rows read off by hand.
  task automatic offer(logic [1:0] op, logic [LetterW-1:0] letter, bit typed,
                       bit t_match, logic [PosW-1:0] t_start);
    in_t  item;
    bit   produces;
    out_t predicted;
    item.opcode = op;
    item.letter = letter;
    while (idle_on && $urandom_range(0, 99) < IdlePct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_data  <= item;
    in_valid <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
    search_step(item, produces, predicted);
    if (produces) begin
      if (typed) begin
        predicted.match       = t_match;
        predicted.start_index = t_start;
      end
      pending_windows = {pending_windows, predicted};
    end
  endtask

  // Reserved opcode, or a letter code beyond the alphabet.
  task automatic offer_noise();
    case ($urandom_range(0, 2))
      0:       offer(OpUnused, LetterW'($urandom), 1'b0, 1'b0, '0);
      1:       offer(OpPattern, LetterW'($urandom_range(Alphabet, 31)), 1'b0, 1'b0, '0);
      default: offer(OpText, LetterW'($urandom_range(Alphabet, 31)), 1'b0, 1'b0, '0);
    endcase
  endtask

  // One search: clear, a pattern over a narrow letter range, then text built
  // mostly from shuffled copies of the pattern so windows line up often.
  task automatic search_round();
    logic [LetterW-1:0] pat_q[$];
    logic [LetterW-1:0] perm[$];
    logic [LetterW-1:0] tmp;
    int plen;
    int tlen;
    int span;
    int base;
    int sent;
    int r;
    int s;
    // Skip the clear now and then: the stale search swallows the pattern.
    if ($urandom_range(0, 9) != 0) begin
      offer(OpClear, LetterW'($urandom), 1'b0, 1'b0, '0);
    end
    r    = $urandom_range(0, 9);
    plen = (r < 7) ? $urandom_range(1, 6) :
           (r < 9) ? $urandom_range(7, 20) : $urandom_range(60, 66);
    span = $urandom_range(1, 4);
    base = $urandom_range(0, Alphabet - span);
    for (int j = 0; j < plen; j++) begin
      if ($urandom_range(0, 19) == 0) offer_noise();
      tmp = LetterW'(base + $urandom_range(0, span - 1));
      offer(OpPattern, tmp, 1'b0, 1'b0, '0);
      if (pat_q.size() < MaxPattern) pat_q = {pat_q, tmp};
    end
    tlen = $urandom_range(1, 2 * plen + 12);
    sent = 0;
    while (sent < tlen) begin
      if ($urandom_range(0, 1) == 1) begin
        perm = pat_q;
        for (int j = perm.size() - 1; j > 0; j--) begin
          s       = $urandom_range(0, j);
          tmp     = perm[j];
          perm[j] = perm[s];
          perm[s] = tmp;
        end
        foreach (perm[j]) offer(OpText, perm[j], 1'b0, 1'b0, '0);
        sent += perm.size();
      end else begin
        offer(OpText, LetterW'(base + $urandom_range(0, span - 1)), 1'b0, 1'b0, '0);
        sent++;
      end
      // Sprinkle late pattern letters, noise and the odd mid-text clear.
      r = $urandom_range(0, 59);
      if (r == 0) begin
        offer(OpPattern, LetterW'($urandom), 1'b0, 1'b0, '0);
      end else if (r == 1) begin
        offer_noise();
      end else if (r == 2) begin
        offer(OpClear, LetterW'($urandom), 1'b0, 1'b0, '0);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  task automatic flag_mismatch(string what, logic [PosW-1:0] got, logic [PosW-1:0] want);
    if (mismatch_cnt < 40) begin
      $display("mismatch at cycle %0d: %s got 0x%0h want 0x%0h", cycle_cnt, what, got, want);
    end
    mismatch_cnt++;
  endtask

  // Drive ready: random stalls, or one long hold-off when the stimulus asks.
  initial begin : result_sink
    int held;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (long_hold_req) begin
        out_ready <= 1'b0;
        for (held = 0; held < HoldCycles; held++) @(posedge clk_i);
        long_hold_req = 1'b0;
      end
      out_ready <= !(idle_on && $urandom_range(0, 99) < IdlePct);
      @(posedge clk_i);
    end
  end

  // Score every output transaction against the oldest prediction.
  always @(posedge clk_i) begin : result_check
    out_t want;
    if (rst_ni && out_valid_o && out_ready) begin
      if (pending_windows.size() == 0) begin
        flag_mismatch("result with none pending, start_index", out_data_o.start_index, '0);
      end else begin
        want = pending_windows.pop_front();
        if (out_data_o.match !== want.match) begin
          flag_mismatch("match", PosW'(out_data_o.match), PosW'(want.match));
        end
        if (out_data_o.start_index !== want.start_index) begin
          flag_mismatch("start_index", out_data_o.start_index, want.start_index);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout with %0d results outstanding", pending_windows.size());
      $display("** sliding_window_anagram_search_top: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    int round;
    clear_search();
    // Hold reset low from time zero, then release it once.
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table.
    foreach (directed[i]) begin
      repeat (directed[i].reps) begin
        offer(directed[i].item.opcode, directed[i].item.letter, directed[i].typed,
              directed[i].t_match, directed[i].t_start);
      end
    end

    // Random searches until the transaction budget is spent.
    round = 0;
    while (items_sent < ItemTarget) begin
      // Stall the output long enough for the queue to back up into the input.
      if (round == 6) long_hold_req = 1'b1;
      // Pause the input until every predicted result has come out.
      if (round == 12) begin
        while (pending_windows.size() != 0) begin
          in_valid <= 1'b0;
          @(posedge clk_i);
        end
      end
      // Run a stretch of back-to-back traffic with no idling on either side.
      idle_on = !(round >= 18 && round < 30);
      search_round();
      round++;
    end

    // Drain: wait for outstanding results, then let the pipe settle.
    in_valid <= 1'b0;
    idle_on = 1'b1;
    while (pending_windows.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatch_cnt == 0) begin
      $display("** sliding_window_anagram_search_top: PASSED **");
    end else begin
      $display("** sliding_window_anagram_search_top: FAILED **");
    end
    $finish;
  end

endmodule
